### hw/rtl/pcibp_pkg.sv
// Shared types and codes for the constrained integer bit packer.
// No dependencies; imported by pcibp_ctrl, pcibp_datapath and the top level.
package pcibp_pkg;

    // request codes
    localparam logic [1:0] REQ_INT   = 2'd0;
    localparam logic [1:0] REQ_RAW   = 2'd1;
    localparam logic [1:0] REQ_FINAL = 2'd2;

    localparam int unsigned RAW_MAX = 64;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the request fields
        logic prep;     // build the bit job from the latched request
        logic step;     // one byte step (emit, pad or merge)
    } pcibp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit;     // the next step completes a byte
        logic done;     // no bits of the current job left
    } pcibp_stat_t;

endpackage

### hw/rtl/per_constrained_int_bit_packer.sv
// Top level of the PER constrained whole number bit packer.
// Depends on pcibp_pkg, pcibp_ctrl and pcibp_datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  input    | in_valid / in_ready    | req_type, int_value, lower_bound, upper_bound,
//           |                        | raw_bits, raw_width
//  output   | out_valid / out_ready  | out_byte, last_of_item, end_of_message
//  config   | cfg_we (no wait)       | cfg_wdata = aligned_mode
//
// One request at a time. A request is latched, then its bit job is built, then the byte
// shifter steps through the output bytes, with an extra step when leftover bits fold into
// the partial byte, before the sequencer returns to idle; a request yields 0..8 bytes.
// The byte shifter emits one byte per cycle while the result register is free to take it.
// out_ready low holds the shifter whenever the result register is still full; the next
// request can be taken while the final byte of the previous one waits there.
// rst_n (asynchronous, active low) clears the packer to an empty message, aligned mode.
module per_constrained_int_bit_packer #(
    parameter int INT_WIDTH = 32    // width of the integer offset, 8..64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] int_value,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    input  logic [63:0]        raw_bits,
    input  logic [6:0]         raw_width,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               last_of_item,
    output logic               end_of_message
);
    import pcibp_pkg::*;

    pcibp_cmd_t  cmd;
    pcibp_stat_t stat;

    // sequencing: idle -> latch request -> build job -> byte steps
    pcibp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // width selection, alignment padding, MSB-first shifter and result register
    pcibp_datapath #(
        .INT_WIDTH (INT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_type       (req_type),
        .int_value      (int_value),
        .lower_bound    (lower_bound),
        .upper_bound    (upper_bound),
        .raw_bits       (raw_bits),
        .raw_width      (raw_width),
        .out_byte       (out_byte),
        .last_of_item   (last_of_item),
        .end_of_message (end_of_message),
        .cmd            (cmd),
        .stat           (stat)
    );

    // a byte step that completes a byte never overwrites an untaken result
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.emit) |-> (!out_valid || out_ready))
        else $error("byte step overwrote a pending result");

    // the message end is always the final byte of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_message) |-> last_of_item)
        else $error("end_of_message without last_of_item");

    // an exhausted job has nothing left to emit
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !stat.emit)
        else $error("finished job still reports a byte");

    // an accepted request keeps the input side closed while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new request taken during latch cycle");

endmodule

### hw/rtl/pcibp_ctrl.sv
// Sequencer for the bit packer: accepts a request, runs the datapath byte steps.
// Depends on pcibp_pkg; drives pcibp_datapath through pcibp_cmd_t.
module pcibp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pcibp_pkg::pcibp_cmd_t  cmd,
    input  pcibp_pkg::pcibp_stat_t stat
);
    import pcibp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (stat.done)
                begin
                    state_next = ST_IDLE;
                end
                else if (!stat.emit)
                begin
                    cmd.step = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/pcibp_datapath.sv
// Datapath of the bit packer: request latch, width selection, bit shifter, partial byte.
// Depends on pcibp_pkg; sequenced by pcibp_ctrl.
module pcibp_datapath #(
    parameter int INT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic [1:0]             req_type,
    input  logic signed [31:0]     int_value,
    input  logic signed [31:0]     lower_bound,
    input  logic signed [31:0]     upper_bound,
    input  logic [63:0]            raw_bits,
    input  logic [6:0]             raw_width,
    output logic [7:0]             out_byte,
    output logic                   last_of_item,
    output logic                   end_of_message,
    input  pcibp_pkg::pcibp_cmd_t  cmd,
    output pcibp_pkg::pcibp_stat_t stat
);
    import pcibp_pkg::*;

    // latched request
    logic [1:0]  req_reg;
    logic [31:0] val_reg;
    logic [31:0] lo_reg;
    logic [31:0] hi_reg;
    logic [63:0] raw_reg;
    logic [6:0]  raw_w_reg;

    // packer state
    logic        aligned_reg;
    logic [7:0]  pb_reg, pb_next;
    logic [2:0]  fill_reg, fill_next;
    logic        wrote_reg, wrote_next;
    logic        pad_reg, pad_next;
    logic        fin_reg, fin_next;
    logic [6:0]  rem_reg, rem_next;
    logic [63:0] sh_reg, sh_next;

    // result register
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        eom_reg;
    logic [7:0]  byte_val;
    logic        last_val;

    // job build
    logic [32:0]          diff;
    logic [63:0]          diff_ext;
    logic [INT_WIDTH-1:0] offset_w;
    logic [63:0]          offset;
    logic signed [32:0]   span;
    logic [3:0]           small_bits;
    logic [3:0]           octets;
    logic [6:0]           job_w;
    logic [63:0]          job_val;
    logic                 job_pad;
    logic                 job_fin;

    // byte step
    logic [3:0]  need;
    logic [6:0]  rem_after;
    logic [7:0]  top8;

    assign diff     = {1'b0, val_reg} - {1'b0, lo_reg};
    assign diff_ext = {{31{diff[32]}}, diff};
    assign offset_w = diff_ext[INT_WIDTH-1:0];
    assign offset   = 64'(offset_w);
    assign span     = $signed({hi_reg[31], hi_reg}) - $signed({lo_reg[31], lo_reg});

    // bit length of the span, at least one (reversed bounds give one bit)
    always_comb
    begin
        small_bits = 4'd1;
        if (!span[32])
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (span[i])
                begin
                    small_bits = 4'(i + 1);
                end
            end
        end
    end

    // whole octets covering the offset, at least one
    always_comb
    begin
        octets = 4'd1;
        for (int k = 1; k < 8; k++)
        begin
            if (offset[8*k +: 8] != 8'd0)
            begin
                octets = 4'(k + 1);
            end
        end
    end

    always_comb
    begin
        job_w   = 7'd0;
        job_val = offset;
        job_pad = 1'b0;
        job_fin = 1'b0;
        unique case (req_reg)
            REQ_INT:
            begin
                if (span == 33'sd0)
                begin
                    job_w = 7'd0;
                end
                else if (span <= 33'sd254)
                begin
                    job_w = 7'(small_bits);
                end
                else if (span == 33'sd255)
                begin
                    job_w   = 7'd8;
                    job_pad = aligned_reg;
                end
                else if (span <= 33'sd65535)
                begin
                    job_w   = 7'd16;
                    job_pad = aligned_reg;
                end
                else
                begin
                    job_w   = {octets, 3'b000};
                    job_pad = aligned_reg;
                end
            end
            REQ_RAW:
            begin
                job_val = raw_reg;
                job_w   = (raw_w_reg > 7'(RAW_MAX)) ? 7'(RAW_MAX) : raw_w_reg;
            end
            REQ_FINAL:
            begin
                job_fin = 1'b1;
                job_val = 64'd0;
                if (!wrote_reg)
                begin
                    job_w = 7'd8;       // empty message: one zero byte
                end
                else
                begin
                    job_pad = 1'b1;
                end
            end
            default:
            begin
                job_w = 7'd0;           // unknown request: no effect
            end
        endcase
    end

    assign need      = 4'd8 - {1'b0, fill_reg};
    assign rem_after = rem_reg - 7'(need);
    assign top8      = sh_reg[63:56];
    assign stat.emit = pad_reg || (rem_reg >= 7'(need));
    assign stat.done = !pad_reg && (rem_reg == 7'd0);

    always_comb
    begin
        pb_next    = pb_reg;
        fill_next  = fill_reg;
        wrote_next = wrote_reg;
        pad_next   = pad_reg;
        fin_next   = fin_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        byte_val   = 8'd0;
        last_val   = 1'b0;
        if (cmd.prep)
        begin
            sh_next  = job_val << (7'd64 - job_w);
            rem_next = job_w;
            pad_next = job_pad && (fill_reg != 3'd0);
            if (pad_next && (job_w == 7'd64))
            begin
                // at most eight bytes a request: after the pad byte the lowest octet is lost
                rem_next = 7'd56;
            end
            fin_next = job_fin;
            if (job_fin)
            begin
                wrote_next = 1'b0;
            end
            else if (job_w != 7'd0)
            begin
                wrote_next = 1'b1;
            end
        end
        else if (cmd.step)
        begin
            if (pad_reg)
            begin
                byte_val  = pb_reg << need;
                last_val  = (rem_reg < 7'd8);
                pad_next  = 1'b0;
                pb_next   = 8'd0;
                fill_next = 3'd0;
            end
            else if (stat.emit)
            begin
                byte_val  = (pb_reg << need) | (top8 >> fill_reg);
                last_val  = (rem_after < 7'd8);
                sh_next   = sh_reg << need;
                rem_next  = rem_after;
                pb_next   = 8'd0;
                fill_next = 3'd0;
            end
            else
            begin
                // fewer bits left than complete a byte: fold them into the partial byte
                pb_next   = (pb_reg << rem_reg[2:0])
                          | (top8 >> (4'd8 - {1'b0, rem_reg[2:0]}));
                fill_next = fill_reg + rem_reg[2:0];
                rem_next  = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aligned_reg <= 1'b1;
            pb_reg      <= 8'd0;
            fill_reg    <= 3'd0;
            wrote_reg   <= 1'b0;
            pad_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            rem_reg     <= 7'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                aligned_reg <= cfg_wdata;
            end
            pb_reg    <= pb_next;
            fill_reg  <= fill_next;
            wrote_reg <= wrote_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            val_reg   <= int_value;
            lo_reg    <= lower_bound;
            hi_reg    <= upper_bound;
            raw_reg   <= raw_bits;
            raw_w_reg <= raw_width;
        end
        if (cmd.step && stat.emit)
        begin
            byte_reg <= byte_val;
            last_reg <= last_val;
            eom_reg  <= last_val && fin_reg;
        end
    end

    assign out_byte       = byte_reg;
    assign last_of_item   = last_reg;
    assign end_of_message = eom_reg;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the PER constrained whole number bit packer.
// Needs pcibp_pkg and per_constrained_int_bit_packer; requests in, bytes checked out.
module testbench;
    import pcibp_pkg::*;

    localparam int INT_WIDTH = 32;
    localparam int QUIET_LIMIT = 4000;      // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 24;       // covers the worst request latency

    localparam logic [1:0] REQ_NONE = 2'd3; // unused code, the packer ignores it

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

    // one request as presented on the input channel
    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [63:0]        raw;
        logic [6:0]         width;
    } pack_req_t;

    // one output byte with its flags
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       eom;
    } out_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = '0;
    logic signed [31:0] int_value = '0;
    logic signed [31:0] lower_bound = '0;
    logic signed [31:0] upper_bound = '0;
    logic [63:0]        raw_bits = '0;
    logic [6:0]         raw_width = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         out_byte;
    logic               last_of_item;
    logic               end_of_message;

    per_constrained_int_bit_packer #(
        .INT_WIDTH(INT_WIDTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .int_value     (int_value),
        .lower_bound   (lower_bound),
        .upper_bound   (upper_bound),
        .raw_bits      (raw_bits),
        .raw_width     (raw_width),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_item  (last_of_item),
        .end_of_message(end_of_message)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Packer prediction: own copy of the pending byte, fill level,
    // message-started flag and the aligned mode setting.
    // ------------------------------------------------------------------
    logic [7:0] pk_partial = '0;
    int         pk_fill = 0;
    logic       pk_wrote = 1'b0;
    logic       pk_aligned = 1'b1;      // reset value of the mode register

    logic [7:0] byte_buf[$];            // bytes completed by the current request
    out_rec_t   exp_bytes[$];           // bytes still owed by the packer
    pack_req_t  req_q[$];               // requests waiting for the driver
    int         live_items = 0;         // requests that actually do something
    int         err_count = 0;

    // append w bits of v, msb first; every full byte, up to eight, goes to byte_buf
    task automatic shift_in(input logic [63:0] v, input int w);
        for (int i = w; i > 0; i--)
        begin
            pk_partial = {pk_partial[6:0], v[i-1]};
            pk_fill++;
            pk_wrote = 1'b1;
            if (pk_fill == 8)
            begin
                // a request returns at most eight bytes
                if (byte_buf.size() < 8)
                    byte_buf.push_back(pk_partial);
                pk_partial = '0;
                pk_fill = 0;
            end
        end
    endtask

    task automatic pad_octet();
        if (pk_fill != 0)
            shift_in(64'd0, 8 - pk_fill);
    endtask

    task automatic predict_int(input pack_req_t r);
        longint      span;
        logic [63:0] offset;
        int          nbits;
        span = longint'(r.hi) - longint'(r.lo) + 1;
        if (span == 1)
            return;
        // offset from the lower bound, wrapped to 32 bits and then to INT_WIDTH
        offset = {32'd0, r.value - r.lo};
        if (INT_WIDTH > 32 && $unsigned(r.value) < $unsigned(r.lo))
            offset[63:32] = '1;
        if (INT_WIDTH < 64)
            offset = offset & ((64'd1 << INT_WIDTH) - 64'd1);
        if (span <= 255)
        begin
            // reversed bounds land here too and take a single bit
            nbits = 1;
            while (nbits < 8 && (longint'(1) << nbits) < span)
                nbits++;
            shift_in(offset, nbits);
        end
        else if (span == 256)
        begin
            if (pk_aligned)
                pad_octet();
            shift_in(offset, 8);
        end
        else if (span <= 65536)
        begin
            if (pk_aligned)
                pad_octet();
            shift_in(offset, 16);
        end
        else
        begin
            // fewest whole octets holding the offset, no length prefix
            if (pk_aligned)
                pad_octet();
            nbits = 8;
            while (nbits < 64 && (offset >> nbits) != 0)
                nbits += 8;
            shift_in(offset, nbits);
        end
    endtask

    // work out the bytes one accepted request owes and queue them
    task automatic pack_request(input pack_req_t r);
        out_rec_t rec;
        int       n;
        byte_buf.delete();
        case (r.kind)
            REQ_INT:
                predict_int(r);
            REQ_RAW:
                shift_in(r.raw, (r.width > 7'd64) ? 64 : int'(r.width));
            REQ_FINAL:
            begin
                // empty message still yields one zero byte
                if (!pk_wrote)
                    shift_in(64'd0, 8);
                else
                    pad_octet();
                pk_partial = '0;
                pk_fill = 0;
                pk_wrote = 1'b0;
            end
            default:
                ;
        endcase
        n = byte_buf.size();
        for (int i = 0; i < n; i++)
        begin
            rec.data = byte_buf[i];
            rec.last = (i == n - 1);
            rec.eom = (i == n - 1) && (r.kind == REQ_FINAL);
            exp_bytes.push_back(rec);
        end
    endtask

    // ------------------------------------------------------------------
    // Request builders. Fields a request does not use still carry noise.
    // ------------------------------------------------------------------
    function automatic pack_req_t filler();
        pack_req_t r;
        r.kind = 2'($urandom_range(0, 3));
        r.value = $urandom;
        r.lo = $urandom;
        r.hi = $urandom;
        r.raw = {$urandom, $urandom};
        r.width = 7'($urandom_range(0, 127));
        return r;
    endfunction

    function automatic pack_req_t int_req(input logic signed [31:0] v,
                                          input logic signed [31:0] lo,
                                          input logic signed [31:0] hi);
        pack_req_t r;
        r = filler();
        r.kind = REQ_INT;
        r.value = v;
        r.lo = lo;
        r.hi = hi;
        return r;
    endfunction

    function automatic pack_req_t raw_req(input logic [63:0] bits, input logic [6:0] w);
        pack_req_t r;
        r = filler();
        r.kind = REQ_RAW;
        r.raw = bits;
        r.width = w;
        return r;
    endfunction

    function automatic pack_req_t final_req();
        pack_req_t r;
        r = filler();
        r.kind = REQ_FINAL;
        return r;
    endfunction

    // constrained integer with a random range class; span is hi - lo
    function automatic pack_req_t rand_int_req();
        longint span;
        longint lo;
        longint off;
        longint room;
        span = 0;
        case ($urandom_range(0, 9))
            0:       span = 0;
            1, 2, 3: span = longint'($urandom_range(1, 254));
            4:       span = 255;
            5:       span = longint'($urandom_range(256, 65535));
            6, 7:    span = longint'($urandom_range(65536, 32'hFFFF_FFFF));
            default: span = -longint'($urandom_range(1, 300));     // reversed bounds
        endcase
        // place lo so that both bounds fit in 32 signed bits
        room = 64'd4294967295 - ((span < 0) ? -span : span);
        lo = -64'sd2147483648 + ((span < 0) ? -span : 0)
             + longint'($urandom_range(0, 32'(room)));
        if (span < 0 || $urandom_range(0, 7) == 0)
            off = longint'($urandom) - lo;                      // anything, out of range too
        else
        begin
            off = longint'($urandom_range(0, 32'(span)));
            if ($urandom_range(0, 2) == 0)
                off = off >> $urandom_range(0, 31);             // short offsets, fewer octets
        end
        return int_req(32'(lo + off), 32'(lo), 32'(lo + span));
    endfunction

    function automatic pack_req_t rand_raw_req();
        int c;
        int w;
        c = $urandom_range(0, 15);
        if (c == 0)
            w = 0;
        else if (c == 1)
            w = $urandom_range(65, 127);
        else if (c == 2)
            w = 64;
        else
            w = $urandom_range(1, 63);
        return raw_req({$urandom, $urandom}, 7'(w));
    endfunction

    task automatic enqueue(input pack_req_t r);
        req_q.push_back(r);
        if (r.kind != REQ_NONE && !(r.kind == REQ_RAW && r.width == '0))
            live_items++;
    endtask

    // mostly whole messages (body then finalize), some left open, some noise
    task automatic add_random(input int want);
        int        start;
        int        n;
        pack_req_t r;
        start = live_items;
        while (live_items - start < want)
        begin
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 1) != 0)
                    r = rand_int_req();
                else
                    r = rand_raw_req();
                enqueue(r);
            end
            case ($urandom_range(0, 9))
                0:       ;                      // message runs on into the next one
                1:       enqueue(filler());     // any code, garbage fields
                default: enqueue(final_req());
            endcase
        end
    endtask

    function automatic int pick_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 17));
    endfunction

    // ------------------------------------------------------------------
    // Request driver: one request from req_q at a time, with a random
    // idle gap after each acceptance. Prediction happens at acceptance.
    // ------------------------------------------------------------------
    pack_req_t cur_req;
    int        in_gap = 0;
    bit        in_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pack_request(cur_req);
            if (!in_valid || in_ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() != 0)
                begin
                    cur_req = req_q.pop_front();
                    req_type <= cur_req.kind;
                    int_value <= cur_req.value;
                    lower_bound <= cur_req.lo;
                    upper_bound <= cur_req.hi;
                    raw_bits <= cur_req.raw;
                    raw_width <= cur_req.width;
                    in_valid <= 1'b1;
                    // occasional switch between gappy traffic and back-to-back bursts
                    if ($urandom_range(0, 15) == 0)
                        in_burst = !in_burst;
                    in_gap = pick_wait(in_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte monitor: compares each accepted byte with the oldest expected
    // one, then stalls out_ready for a random number of cycles.
    // ------------------------------------------------------------------
    int       out_gap = 0;
    bit       out_burst = 1'b0;
    out_rec_t seen_exp;

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            err_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (exp_bytes.size() == 0)
                begin
                    err_count++;
                    $error("out_byte: expected nothing, got 0x%0h", out_byte);
                end
                else
                begin
                    seen_exp = exp_bytes.pop_front();
                    check_field("out_byte", seen_exp.data, out_byte);
                    check_field("last_of_item", seen_exp.last, last_of_item);
                    check_field("end_of_message", seen_exp.eom, end_of_message);
                end
                if ($urandom_range(0, 15) == 0)
                    out_burst = !out_burst;
                out_gap = pick_wait(out_burst);
                if (out_gap != 0)
                begin
                    out_ready <= 1'b0;
                    out_gap = out_gap - 1;
                end
                else
                    out_ready <= 1'b1;
            end
            else if (!out_ready)
            begin
                if (out_gap != 0)
                    out_gap = out_gap - 1;
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // watchdog: a hung handshake on either side ends the run
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: wait for the packer to go quiet, then reconfigure.
    // ------------------------------------------------------------------
    task automatic settle();
        @(negedge clk);
        while (req_q.size() != 0 || in_valid)
            @(negedge clk);
        while (exp_bytes.size() != 0)
            @(negedge clk);
        // a request with no bytes may still be in flight
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic mode);
        settle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        pk_aligned = mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // aligned mode, directed
        configure(1'b1);
        enqueue(final_req());                                   // empty message
        enqueue(int_req(32'sd5, 32'sd5, 32'sd5));               // range of one, writes nothing
        enqueue(final_req());                                   // still empty
        enqueue(int_req(32'sd1, 32'sd0, 32'sd1));               // one bit
        enqueue(int_req(32'sd254, 32'sd0, 32'sd254));           // range 255, eight bits
        enqueue(int_req(32'sd127, -32'sd128, 32'sd127));        // range 256, aligned
        enqueue(raw_req(64'h5, 7'd3));
        enqueue(int_req(32'sd65535, 32'sd0, 32'sd65535));       // sixteen bits, aligned
        enqueue(int_req(S32_MAX, S32_MIN, S32_MAX));            // full range, four octets
        enqueue(int_req(S32_MIN, S32_MIN, S32_MAX));            // zero offset, one octet
        enqueue(int_req(32'sd100, 32'sd10, 32'sd20));           // out of range, truncated
        enqueue(int_req(32'sd0, S32_MAX, S32_MIN));             // reversed bounds
        enqueue(int_req(32'sd7, 32'sd7, 32'sd6));               // zero range
        enqueue(raw_req(64'hFFFF_FFFF_FFFF_FFFF, 7'd0));        // zero width
        enqueue(raw_req(64'hFFFF_FFFF_FFFF_FFFF, 7'd127));      // width saturates at 64
        enqueue(raw_req(64'h0123_4567_89AB_CDEF, 7'd64));
        begin
            pack_req_t r;
            r = filler();
            r.kind = REQ_NONE;                                   // ignored code
            enqueue(r);
        end
        enqueue(final_req());
        enqueue(raw_req(64'h7F, 7'd7));
        enqueue(raw_req(64'hA5A5_5A5A_C3C3_3C3C, 7'd64));       // eight bytes out
        enqueue(final_req());                                   // pads the pending bits
        enqueue(int_req(32'sd2, 32'sd0, 32'sd3));
        enqueue(raw_req(64'h2A, 7'd6));                         // byte ends exactly
        enqueue(final_req());                                   // nothing pending, no bytes

        // unaligned mode, directed
        configure(1'b0);
        enqueue(int_req(32'sd1, 32'sd0, 32'sd1));
        enqueue(int_req(32'sd171, 32'sd0, 32'sd255));           // range 256, no padding
        enqueue(int_req(32'sd4660, 32'sd0, 32'sd65535));
        enqueue(int_req(32'sd70000, 32'sd0, 32'sd100000));
        enqueue(final_req());                                   // still zero padded
        enqueue(final_req());

        // random traffic, alternating modes
        for (int p = 0; p < 4; p++)
        begin
            configure((p % 2) == 0);
            add_random(47);
        end
        settle();

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
